[src/pwm_period_duty_register_calc_unit_assert.svh]
// assertion macros for the pwm period and duty register calculator
`ifndef PWM_PERIOD_DUTY_REGISTER_CALC_UNIT_ASSERT_SVH
`define PWM_PERIOD_DUTY_REGISTER_CALC_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PDRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pdrc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PDRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pdrc assertion failed");

`endif

[src/pdrc_pkg.sv]
// shared types and constants of the pwm period and duty register calculator
`timescale 1ns / 1ps
package pdrc_pkg;

	localparam int NUM_CHANNELS_DEF = 8;

	localparam int VALUE_W  = 32;
	localparam int CLOCK_W  = 8;
	localparam int NUM_W    = VALUE_W + CLOCK_W;
	localparam int CH_W     = 4;
	localparam int MASK_W   = 16;
	localparam int COUNT_W  = 16;
	localparam int CFG_IDX_W = 2;

	// 1000 * p = 125 * 2^(log2(p) + 3): one divide by 125, then a shift per prescaler
	localparam int DIV_CONST   = 125;
	localparam int REM_W       = 7;
	localparam int DIGIT_W     = 8;
	localparam int DIVX_W      = REM_W + DIGIT_W;
	localparam int DPROD_W     = 30;
	// floor(x / 125) = (x * 33555) >> 22 for every x below 2^15
	localparam int RECIP_MUL   = 33555;
	localparam int RECIP_SHIFT = 22;
	localparam int DIV_STEPS   = NUM_W / DIGIT_W;
	localparam int CNT_W       = 3;
	localparam int SHAMT_W     = 4;
	localparam int SUM_W       = 34;
	localparam int ROUND_BASE  = 4;
	localparam int DIV_SHIFT   = 3;
	localparam int COUNT_LIMIT = 65536;

	// log2 of the prescalers 1, 8, 64 and 256
	localparam logic [SHAMT_W-1:0] PS_LOG2_1   = 4'd0;
	localparam logic [SHAMT_W-1:0] PS_LOG2_8   = 4'd3;
	localparam logic [SHAMT_W-1:0] PS_LOG2_64  = 4'd6;
	localparam logic [SHAMT_W-1:0] PS_LOG2_256 = 4'd8;

	localparam logic [CLOCK_W-1:0]   CLOCK_MHZ_RESET = 8'd40;
	localparam logic [COUNT_W-1:0]   PERIOD_RESET    = 16'hFFFF;
	localparam logic [CH_W-1:0]      COUNTER_RESET_CH = 4'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MHZ     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOWED = 2'd1;

	typedef enum logic [1:0] {
		OP_SET_PERIOD = 2'd0,
		OP_SELECT     = 2'd1,
		OP_DUTY       = 2'd2,
		OP_UNKNOWN    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_WRITABLE = 3'd1,
		ST_NOT_ENABLED  = 3'd2,
		ST_NO_CHANNEL   = 3'd3,
		ST_BAD_PERIOD   = 3'd4,
		ST_BAD_REQUEST  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MULT,
		S_DIV,
		S_EVAL,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic mult;
		logic div_step;
		logic eval;
		logic write_out;
	} cmd_t;

	typedef struct packed {
		logic needs_math;
		logic div_last;
		logic eval_last;
		logic out_free;
	} stat_t;

endpackage

[src/pdrc_ctrl.sv]
// sequencer of the pwm period and duty register calculator
`timescale 1ns / 1ps
module pdrc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pdrc_pkg::stat_t stat,
	output pdrc_pkg::cmd_t  cmd
);
	import pdrc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = stat.needs_math ? S_MULT : S_FINISH;
			end
			S_MULT: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (stat.div_last) state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.eval_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_DECODE: cmd.decode = 1'b1;
			S_MULT:   cmd.mult = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_EVAL:   cmd.eval = 1'b1;
			S_FINISH: cmd.write_out = stat.out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[src/pdrc_datapath.sv]
// registers, multiplier, divide by 125 and count evaluation
`timescale 1ns / 1ps
module pdrc_datapath #(
	parameter int NUM_CHANNELS = pdrc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pdrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdrc_pkg::CLOCK_W-1:0]      cfg_wdata,
	input  logic [1:0]                        opcode,
	input  logic [pdrc_pkg::VALUE_W-1:0]      operand,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [2:0]                        status,
	output logic [1:0]                        prescale_index,
	output logic [pdrc_pkg::COUNT_W-1:0]      period_value,
	output logic [pdrc_pkg::CH_W-1:0]         active_channel,
	output logic [pdrc_pkg::COUNT_W-1:0]      compare_value,
	output logic                              counter_cleared,
	input  pdrc_pkg::cmd_t                    cmd,
	output pdrc_pkg::stat_t                   stat
);
	import pdrc_pkg::*;

	localparam logic [CH_W:0] NCH = (CH_W+1)'(NUM_CHANNELS);

	// configuration and architectural state
	logic [CLOCK_W-1:0] clock_mhz_q;
	logic               write_allowed_q;
	logic [CH_W-1:0]    sel_ch_q;
	logic [MASK_W-1:0]  enable_mask_q;
	logic [1:0]         prescale_q;
	logic [COUNT_W-1:0] period_q;

	// per-command working registers
	op_t                op_q;
	logic [VALUE_W-1:0] value_q;
	logic [NUM_W-1:0]   num_q;
	logic [REM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         k_q;
	status_t            res_status_q;
	logic [COUNT_W-1:0] res_compare_q;
	logic               res_cleared_q;

	logic                out_valid_q;
	logic [2:0]          out_status_q;
	logic [1:0]          out_prescale_q;
	logic [COUNT_W-1:0]  out_period_q;
	logic [CH_W-1:0]     out_channel_q;
	logic [COUNT_W-1:0]  out_compare_q;
	logic                out_cleared_q;

	status_t             chk;
	logic [NUM_W-1:0]    prod;
	logic [DIVX_W-1:0]   div_x;
	logic [DPROD_W-1:0]  div_prod;
	logic [DIGIT_W-1:0]  div_q;
	logic [DIVX_W-1:0]   div_r;
	logic [SHAMT_W-1:0]  ps_log2;
	logic [SHAMT_W-1:0]  shamt;
	logic [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]    cand;
	logic                fits;
	logic [COUNT_W-1:0]  cand_m1;
	logic                ch_clears;

	// duty write checks, in priority order
	always_comb begin
		priority if (!write_allowed_q) begin
			chk = ST_NOT_WRITABLE;
		end else if (!enable_mask_q[sel_ch_q]) begin
			chk = ST_NOT_ENABLED;
		end else if ({1'b0, sel_ch_q} >= NCH) begin
			chk = ST_NO_CHANNEL;
		end else begin
			chk = ST_OK;
		end
	end

	assign ch_clears = (sel_ch_q == COUNTER_RESET_CH);
	assign prod = NUM_W'(value_q) * NUM_W'(clock_mhz_q);

	// one byte of the divide by 125, quotient digit by reciprocal multiply
	assign div_x    = {rem_q, num_q[NUM_W-1 -: DIGIT_W]};
	assign div_prod = DPROD_W'(div_x) * DPROD_W'(RECIP_MUL);
	assign div_q    = div_prod[RECIP_SHIFT +: DIGIT_W];
	assign div_r    = div_x - DIVX_W'(div_q) * DIVX_W'(DIV_CONST);

	always_comb begin
		unique case (k_q)
			2'd0: ps_log2 = PS_LOG2_1;
			2'd1: ps_log2 = PS_LOG2_8;
			2'd2: ps_log2 = PS_LOG2_64;
			2'd3: ps_log2 = PS_LOG2_256;
		endcase
	end

	// round and scale: (Q + 2^(s-1)) >> s with s = log2(p) + 3
	assign shamt   = ps_log2 + SHAMT_W'(DIV_SHIFT);
	assign sum     = num_q[SUM_W-1:0] + (SUM_W'(ROUND_BASE) << ps_log2);
	assign cand    = sum >> shamt;
	assign fits    = (cand != '0) && (cand <= SUM_W'(COUNT_LIMIT));
	assign cand_m1 = COUNT_W'(cand - SUM_W'(1));

	assign stat.needs_math = (op_q == OP_SET_PERIOD) ||
		((op_q == OP_DUTY) && (chk == ST_OK) && (value_q != '0));
	assign stat.div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.eval_last = (op_q == OP_DUTY) || fits || (k_q == 2'd3);
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mhz_q     <= CLOCK_MHZ_RESET;
			write_allowed_q <= 1'b1;
			sel_ch_q        <= '0;
			enable_mask_q   <= '0;
			prescale_q      <= '0;
			period_q        <= PERIOD_RESET;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_CLOCK_MHZ)) clock_mhz_q <= cfg_wdata;
			if (cfg_we && (cfg_index == CFG_WRITE_ALLOWED)) write_allowed_q <= cfg_wdata[0];
			if (cmd.decode && (op_q == OP_SELECT)) begin
				sel_ch_q      <= value_q[CH_W-1:0];
				enable_mask_q <= enable_mask_q | (MASK_W'(1) << value_q[CH_W-1:0]);
			end
			if (cmd.eval && (op_q == OP_SET_PERIOD) && fits) begin
				prescale_q <= k_q;
				period_q   <= cand_m1;
			end
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			value_q <= operand;
		end
		if (cmd.decode) begin
			res_compare_q <= '0;
			res_cleared_q <= 1'b0;
			unique case (op_q)
				OP_SET_PERIOD: begin
					res_status_q <= ST_OK;
					k_q <= 2'd0;
				end
				OP_SELECT: res_status_q <= ST_OK;
				OP_DUTY: begin
					res_status_q  <= chk;
					res_cleared_q <= (chk == ST_OK) && ch_clears;
					k_q <= prescale_q;
				end
				OP_UNKNOWN: res_status_q <= ST_BAD_REQUEST;
				default: res_status_q <= ST_BAD_REQUEST;
			endcase
		end
		if (cmd.mult) begin
			num_q <= prod;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= div_r[REM_W-1:0];
			num_q <= {num_q[NUM_W-DIGIT_W-1:0], div_q};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.eval) begin
			if (op_q == OP_DUTY) begin
				res_compare_q <= cand_m1;
				res_cleared_q <= ch_clears;
			end else if (fits) begin
				res_cleared_q <= 1'b1;
			end else if (k_q == 2'd3) begin
				res_status_q <= ST_BAD_PERIOD;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
		if (cmd.write_out) begin
			out_status_q   <= res_status_q;
			out_prescale_q <= prescale_q;
			out_period_q   <= period_q;
			out_channel_q  <= sel_ch_q;
			out_compare_q  <= res_compare_q;
			out_cleared_q  <= res_cleared_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign prescale_index  = out_prescale_q;
	assign period_value    = out_period_q;
	assign active_channel  = out_channel_q;
	assign compare_value   = out_compare_q;
	assign counter_cleared = out_cleared_q;

endmodule

[src/pwm_period_duty_register_calc_unit.sv]
// top level of the pwm period and duty register calculator
//
// usage: one command word enters on in_valid / in_stall (opcode, operand) and
// one result word leaves on out_valid / out_stall for every command.
// opcodes: set period (value in ns), select channel, write duty (ns), unknown.
// timing: a word is taken when in_valid is high and in_stall is low; the block
// then holds in_stall high until that word's result is in the output register.
// path: select, unknown and rejected or zero duty writes go from decode straight
// to finish; a duty conversion and a period pass through the multiply, a 5-step
// divide by 125 (one quotient byte per cycle by reciprocal multiply) and an
// evaluation, with up to four prescaler trials for a period.
// throughput: one command at a time; in_stall falls in the same cycle that
// out_valid rises, so the next word can then be taken.
// stall: a result waits in the output register while out_stall is high; the
// next command may be accepted meanwhile but cannot finish until it leaves.
// reset: arst_n clears the channel state, period to 0xffff, clock_mhz to 40
// and write permission to 1; the user is to write configuration on cfg_we
// only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module pwm_period_duty_register_calc_unit #(
	parameter int NUM_CHANNELS = pdrc_pkg::NUM_CHANNELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdrc_pkg::CLOCK_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic [pdrc_pkg::VALUE_W-1:0]   operand,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [1:0]                     prescale_index,
	output logic [pdrc_pkg::COUNT_W-1:0]   period_value,
	output logic [pdrc_pkg::CH_W-1:0]      active_channel,
	output logic [pdrc_pkg::COUNT_W-1:0]   compare_value,
	output logic                           counter_cleared
);
	import pdrc_pkg::*;
	`include "pwm_period_duty_register_calc_unit_assert.svh"

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	pdrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdrc_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.opcode          (opcode),
		.operand         (operand),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.status          (status),
		.prescale_index  (prescale_index),
		.period_value    (period_value),
		.active_channel  (active_channel),
		.compare_value   (compare_value),
		.counter_cleared (counter_cleared),
		.cmd             (cmd),
		.stat            (stat)
	);

	// an accepted word keeps the input side busy in the next cycle
	`PDRC_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// the input side frees up only together with a fresh result
	`PDRC_ASSERT_IMP(a_free_has_result, clk, arst_n, $fell(in_stall), out_valid)
	// a new result only appears at the end of a busy command
	`PDRC_ASSERT_IMP(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule
